/* design/tss_pkg.sv */
package tss_pkg;

  // fixed field widths
  localparam int unsigned OP_W        = 3;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned STATUS_W    = 2;

  // a dump emits at most this many words
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned CNT_W       = 4;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH1 = 3'd0,
    OP_PUSH2 = 3'd1,
    OP_POP1  = 3'd2,
    OP_POP2  = 3'd3,
    OP_DUMP1 = 3'd4,
    OP_DUMP2 = 3'd5
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // source of the next result beat
  typedef enum logic [1:0] {
    SEL_OK,
    SEL_OVF,
    SEL_UDF,
    SEL_RDATA
  } out_sel_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic     latch;
    logic     push;
    logic     pop;
    logic     dump_start;
    logic     dump_next;
    logic     out_load;
    out_sel_e out_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_e op;
    logic    can_push;
    logic    empty;
    logic    out_last;
  } sts_t;

endpackage

/* design/tss_if.sv */
// input channel: one operation per beat
interface tss_in_if;
  logic                              valid;
  logic                              ready;
  logic [tss_pkg::OP_W-1:0]          opcode;
  logic signed [tss_pkg::WORD_W-1:0] push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

// output channel: one result per beat
interface tss_out_if;
  logic                                valid;
  logic                                ready;
  logic [tss_pkg::STATUS_W-1:0]        status;
  logic signed [tss_pkg::WORD_W-1:0]   data_word;
  logic                                last;

  modport source (output valid, output status, output data_word, output last, input ready);
  modport sink   (input valid, input status, input data_word, input last, output ready);
endinterface

/* design/tss_ram.sv */
module tss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/tss_ctrl.sv */
module tss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  tss_pkg::sts_t sts_i,
  output tss_pkg::cmd_t cmd_o
);

  tss_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tss_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tss_pkg::S_IDLE: begin
        if (in_valid_i) state_d = tss_pkg::S_EXEC;
      end
      tss_pkg::S_EXEC: begin
        case (sts_i.op)
          tss_pkg::OP_PUSH1, tss_pkg::OP_PUSH2: state_d = tss_pkg::S_RESP;
          tss_pkg::OP_POP1, tss_pkg::OP_POP2,
          tss_pkg::OP_DUMP1, tss_pkg::OP_DUMP2: begin
            state_d = sts_i.empty ? tss_pkg::S_RESP : tss_pkg::S_RDWAIT;
          end
          default: state_d = tss_pkg::S_IDLE;
        endcase
      end
      tss_pkg::S_RDWAIT: state_d = tss_pkg::S_RESP;
      tss_pkg::S_RESP: begin
        if (out_ready_i) begin
          state_d = sts_i.out_last ? tss_pkg::S_IDLE : tss_pkg::S_RDWAIT;
        end
      end
      default: state_d = tss_pkg::S_IDLE;
    endcase
  end

  // commands and handshake outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.out_sel = tss_pkg::SEL_OK;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      tss_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      tss_pkg::S_EXEC: begin
        case (sts_i.op)
          tss_pkg::OP_PUSH1, tss_pkg::OP_PUSH2: begin
            cmd_o.out_load = 1'b1;
            cmd_o.push     = sts_i.can_push;
            cmd_o.out_sel  = sts_i.can_push ? tss_pkg::SEL_OK : tss_pkg::SEL_OVF;
          end
          tss_pkg::OP_POP1, tss_pkg::OP_POP2: begin
            cmd_o.out_load = sts_i.empty;
            cmd_o.out_sel  = tss_pkg::SEL_UDF;
            cmd_o.pop      = !sts_i.empty;
          end
          tss_pkg::OP_DUMP1, tss_pkg::OP_DUMP2: begin
            cmd_o.out_load   = sts_i.empty;
            cmd_o.out_sel    = tss_pkg::SEL_UDF;
            cmd_o.dump_start = !sts_i.empty;
          end
          default: ;
        endcase
      end
      tss_pkg::S_RDWAIT: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_sel  = tss_pkg::SEL_RDATA;
      end
      tss_pkg::S_RESP: begin
        out_valid_o     = 1'b1;
        cmd_o.dump_next = out_ready_i && !sts_i.out_last;
      end
      default: ;
    endcase
  end

endmodule

/* design/tss_dp.sv */
module tss_dp #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tss_pkg::cmd_t                     cmd_i,
  output tss_pkg::sts_t                     sts_o,
  input  logic [tss_pkg::OP_W-1:0]          opcode_i,
  input  logic signed [tss_pkg::WORD_W-1:0] push_value_i,
  output logic [tss_pkg::STATUS_W-1:0]      status_o,
  output logic signed [tss_pkg::WORD_W-1:0] data_word_o,
  output logic                              last_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (PW > tss_pkg::CNT_W) ? PW : tss_pkg::CNT_W;

  tss_pkg::opcode_e             op_q;
  logic [tss_pkg::WORD_W-1:0]   val_q;
  logic [PW-1:0]                lower_q, lower_d;
  logic [PW-1:0]                upper_q, upper_d;
  logic [AW-1:0]                rd_ptr_q, rd_ptr_d;
  logic [tss_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  tss_pkg::status_e             status_q;
  logic [tss_pkg::WORD_W-1:0]   data_q;
  logic                         last_q;

  logic                         is_s1, is_dump;
  logic                         we, re;
  logic [AW-1:0]                waddr, raddr, top_addr;
  logic [tss_pkg::WORD_W-1:0]   rdata;
  logic [PW-1:0]                fill;
  logic [CMP_W-1:0]             fill_ext, n_ext;

  // operation decode
  assign is_s1 = (op_q == tss_pkg::OP_PUSH1) || (op_q == tss_pkg::OP_POP1) ||
                 (op_q == tss_pkg::OP_DUMP1);
  assign is_dump = (op_q == tss_pkg::OP_DUMP1) || (op_q == tss_pkg::OP_DUMP2);

  // status toward the controller
  assign sts_o.op       = op_q;
  assign sts_o.can_push = lower_q < upper_q;
  assign sts_o.empty    = is_s1 ? (lower_q == '0) : (upper_q == PW'(DEPTH));
  assign sts_o.out_last = last_q;

  // top word of the selected stack and its fill level
  assign top_addr = is_s1 ? AW'(lower_q - PW'(1)) : AW'(upper_q);
  assign fill     = is_s1 ? lower_q : PW'(PW'(DEPTH) - upper_q);
  assign fill_ext = CMP_W'(fill);
  assign n_ext    = (fill_ext > CMP_W'(tss_pkg::MAX_RESULTS)) ?
                    CMP_W'(tss_pkg::MAX_RESULTS) : fill_ext;

  // memory port control
  assign we    = cmd_i.push;
  assign waddr = is_s1 ? AW'(lower_q) : AW'(upper_q - PW'(1));
  assign re    = cmd_i.pop || cmd_i.dump_start || cmd_i.dump_next;
  assign raddr = cmd_i.dump_next ? rd_ptr_q : top_addr;

  tss_ram #(
    .WIDTH (tss_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (val_q),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // stack pointers
  always_comb begin
    lower_d = lower_q;
    upper_d = upper_q;
    if (cmd_i.push) begin
      if (is_s1) lower_d = lower_q + PW'(1);
      else       upper_d = upper_q - PW'(1);
    end else if (cmd_i.pop) begin
      if (is_s1) lower_d = lower_q - PW'(1);
      else       upper_d = upper_q + PW'(1);
    end
  end

  // dump walk: next address and words left
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (cmd_i.dump_start) begin
      rd_ptr_d = is_s1 ? top_addr - AW'(1) : top_addr + AW'(1);
      cnt_d    = tss_pkg::CNT_W'(n_ext);
    end else if (cmd_i.dump_next) begin
      rd_ptr_d = is_s1 ? rd_ptr_q - AW'(1) : rd_ptr_q + AW'(1);
      cnt_d    = cnt_q - tss_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= '0;
      upper_q <= PW'(DEPTH);
    end else begin
      lower_q <= lower_d;
      upper_q <= upper_d;
    end
  end

  // item and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= tss_pkg::opcode_e'(opcode_i);
      val_q <= push_value_i;
    end
    rd_ptr_q <= rd_ptr_d;
    cnt_q    <= cnt_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        tss_pkg::SEL_OK: begin
          status_q <= tss_pkg::ST_OK;
          data_q   <= '0;
          last_q   <= 1'b1;
        end
        tss_pkg::SEL_OVF: begin
          status_q <= tss_pkg::ST_OVERFLOW;
          data_q   <= '0;
          last_q   <= 1'b1;
        end
        tss_pkg::SEL_UDF: begin
          status_q <= tss_pkg::ST_UNDERFLOW;
          data_q   <= '0;
          last_q   <= 1'b1;
        end
        tss_pkg::SEL_RDATA: begin
          status_q <= tss_pkg::ST_OK;
          data_q   <= rdata;
          last_q   <= is_dump ? (cnt_q == tss_pkg::CNT_W'(1)) : 1'b1;
        end
        default: begin
          status_q <= tss_pkg::ST_OK;
          data_q   <= '0;
          last_q   <= 1'b1;
        end
      endcase
    end
  end

  assign status_o    = status_q;
  assign data_word_o = data_q;
  assign last_o      = last_q;

endmodule

/* design/two_stacks_shared_array.sv */
// Two stacks in one memory of DEPTH 32-bit words: stack one grows up from
// word 0, stack two grows down from word DEPTH-1.
// in_i carries one operation per beat (opcode, push_value); out_o carries
// result beats (status, data_word, last). Every operation gives one beat
// with last set, except a dump of a non-empty stack, which gives one beat
// per word from top to bottom (at most 8) with last on the final one.
// Unused opcodes give no beat.
// Timing: one operation at a time. A push or an error loads its result in
// the execute state and shows it in the response state; a pop or the first
// word of a dump passes the read-wait state in between, since the memory
// read is registered. Each further dump word passes the read-wait state
// again once the previous beat is taken. The next input beat can be taken
// the cycle after the final result beat is taken. After an unused opcode
// the block goes from the execute state back to idle for the next beat.
// When the receiver stalls the result beat holds and no input is taken.
// Reset empties both stacks; memory contents are not cleared.
module two_stacks_shared_array #(
  parameter int unsigned DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tss_in_if.sink     in_i,
  tss_out_if.source  out_o
);

  tss_pkg::cmd_t cmd;
  tss_pkg::sts_t sts;

  tss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .opcode_i     (in_i.opcode),
    .push_value_i (in_i.push_value),
    .status_o     (out_o.status),
    .data_word_o  (out_o.data_word),
    .last_o       (out_o.last)
  );

endmodule

/* design/tss_checker.sv */
module tss_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [tss_pkg::STATUS_W-1:0]      status_i,
  input logic signed [tss_pkg::WORD_W-1:0] data_word_i,
  input logic                              last_i
);

  // a stalled result beat stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // one operation at a time: no input while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input taken while a result is pending");

  // an accepted beat closes the input side for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken on back-to-back cycles");

  // a dump word that is not the final one keeps the input closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> !in_ready_i)
    else $error("input reopened in the middle of a dump");

  // an error beat carries zero data and ends the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != tss_pkg::ST_OK) |-> (data_word_i == '0) && last_i)
    else $error("error beat with data or without last");

endmodule

bind two_stacks_shared_array tss_checker u_tss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .data_word_i (out_o.data_word),
  .last_i      (out_o.last)
);

/* verif/tb_two_stacks_shared_array.sv */
module tb_two_stacks_shared_array;

  localparam int unsigned DEPTH       = 8;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 20;

  // opcodes with no operation behind them
  localparam logic [tss_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [tss_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

  typedef struct {
    logic [tss_pkg::OP_W-1:0]          op;
    logic signed [tss_pkg::WORD_W-1:0] value;
  } stack_op_t;

  typedef struct {
    tss_pkg::status_e                  status;
    logic signed [tss_pkg::WORD_W-1:0] word;
    logic                              last;
  } stack_result_t;

  logic clk_i;
  logic rst_ni;

  tss_in_if  in_bus ();
  tss_out_if out_bus ();

  two_stacks_shared_array #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // operations waiting to be sent, and results still owed by the block
  stack_op_t     ops_to_send[$];
  stack_result_t owed_results[$];

  // shadow copy of both stacks
  logic signed [tss_pkg::WORD_W-1:0] shadow_words[DEPTH];
  int unsigned                       lower_depth;
  int unsigned                       upper_top;

  int unsigned ops_queued;
  int unsigned ops_taken;
  int unsigned beats_taken;
  int unsigned mismatches;
  int unsigned send_gap;
  int unsigned recv_hold;
  int unsigned quiet_cycles;
  bit          long_hold_done;
  bit          idle_on;

  // clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic void owe(tss_pkg::status_e status,
                              logic signed [tss_pkg::WORD_W-1:0] word, logic last);
    stack_result_t r;
    r.status = status;
    r.word   = word;
    r.last   = last;
    owed_results.push_back(r);
  endfunction

  // expected results of one operation, updating the shadow stacks
  function automatic void predict_stacks(logic [tss_pkg::OP_W-1:0] op,
                                         logic signed [tss_pkg::WORD_W-1:0] value);
    int unsigned n;
    case (op)
      tss_pkg::OP_PUSH1: begin
        if (lower_depth < upper_top) begin
          shadow_words[lower_depth] = value;
          lower_depth++;
          owe(tss_pkg::ST_OK, '0, 1'b1);
        end else begin
          owe(tss_pkg::ST_OVERFLOW, '0, 1'b1);
        end
      end
      tss_pkg::OP_PUSH2: begin
        if (lower_depth < upper_top) begin
          upper_top--;
          shadow_words[upper_top] = value;
          owe(tss_pkg::ST_OK, '0, 1'b1);
        end else begin
          owe(tss_pkg::ST_OVERFLOW, '0, 1'b1);
        end
      end
      tss_pkg::OP_POP1: begin
        if (lower_depth == 0) begin
          owe(tss_pkg::ST_UNDERFLOW, '0, 1'b1);
        end else begin
          lower_depth--;
          owe(tss_pkg::ST_OK, shadow_words[lower_depth], 1'b1);
        end
      end
      tss_pkg::OP_POP2: begin
        if (upper_top >= DEPTH) begin
          owe(tss_pkg::ST_UNDERFLOW, '0, 1'b1);
        end else begin
          owe(tss_pkg::ST_OK, shadow_words[upper_top], 1'b1);
          upper_top++;
        end
      end
      tss_pkg::OP_DUMP1: begin
        if (lower_depth == 0) begin
          owe(tss_pkg::ST_UNDERFLOW, '0, 1'b1);
        end else begin
          n = (lower_depth > tss_pkg::MAX_RESULTS) ? tss_pkg::MAX_RESULTS : lower_depth;
          for (int unsigned i = 0; i < n; i++)
            owe(tss_pkg::ST_OK, shadow_words[lower_depth - 1 - i], i + 1 == n);
        end
      end
      tss_pkg::OP_DUMP2: begin
        if (upper_top >= DEPTH) begin
          owe(tss_pkg::ST_UNDERFLOW, '0, 1'b1);
        end else begin
          n = DEPTH - upper_top;
          if (n > tss_pkg::MAX_RESULTS) n = tss_pkg::MAX_RESULTS;
          for (int unsigned i = 0; i < n; i++)
            owe(tss_pkg::ST_OK, shadow_words[upper_top + i], i + 1 == n);
        end
      end
      default: begin
        // unused opcode: no result, no state change
      end
    endcase
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  // input driver: show the oldest pending operation, with random gaps when idling is on
  always @(posedge clk_i or negedge rst_ni) begin : feed
    bit offer;
    if (!rst_ni) begin
      in_bus.valid      <= 1'b0;
      in_bus.opcode     <= '0;
      in_bus.push_value <= '0;
      send_gap = 0;
    end else begin
      offer = 1'b0;
      if (in_bus.valid && in_bus.ready) void'(ops_to_send.pop_front());
      if (in_bus.valid && !in_bus.ready) begin
        // an offered beat stays up until it is taken
        offer = 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
      end else if (idle_on && $urandom_range(0, 99) < 6) begin
        send_gap = $urandom_range(1, 17) - 1;
      end else begin
        offer = (ops_to_send.size() != 0);
      end
      in_bus.valid <= offer;
      if (offer) begin
        in_bus.opcode     <= ops_to_send[0].op;
        in_bus.push_value <= ops_to_send[0].value;
      end
    end
  end

  // result receiver: random stall bursts when idling is on, plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      recv_hold = 0;
      long_hold_done = 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold--;
      out_bus.ready <= 1'b0;
    end else if (!long_hold_done && beats_taken >= 120) begin
      long_hold_done = 1'b1;
      recv_hold = 150;
      out_bus.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 8) begin
      recv_hold = $urandom_range(1, 17) - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // monitor: check result beats first, then predict for a taken operation
  always @(posedge clk_i) begin : watch
    stack_result_t want;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        beats_taken++;
        if (owed_results.size() == 0) begin
          flag_error($sformatf("unexpected beat status %0d word %h last %0b",
                               out_bus.status, out_bus.data_word, out_bus.last));
        end else begin
          want = owed_results.pop_front();
          if (out_bus.status !== want.status)
            flag_error($sformatf("status got %0d want %0d", out_bus.status, want.status));
          if (out_bus.data_word !== want.word)
            flag_error($sformatf("data_word got %h want %h", out_bus.data_word, want.word));
          if (out_bus.last !== want.last)
            flag_error($sformatf("last got %0b want %0b", out_bus.last, want.last));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        ops_taken++;
        predict_stacks(in_bus.opcode, in_bus.push_value);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send(logic [tss_pkg::OP_W-1:0] op, logic signed [tss_pkg::WORD_W-1:0] value);
    stack_op_t item;
    item.op    = op;
    item.value = value;
    ops_to_send.push_back(item);
    ops_queued++;
  endtask

  function automatic logic signed [tss_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // random pushes, pops, dumps and unused opcodes, biased toward pushes or pops
  task automatic send_mix(int count, int push_pct, int dump_pct);
    int unsigned r;
    bit          upper;
    for (int k = 0; k < count; k++) begin
      r     = $urandom_range(0, 99);
      upper = ($urandom_range(0, 1) == 1);
      if (r < 3)
        send(($urandom_range(0, 1) == 1) ? OP_SPARE_B : OP_SPARE_A, pick_word());
      else if (r < 3 + dump_pct)
        send(upper ? tss_pkg::OP_DUMP2 : tss_pkg::OP_DUMP1, pick_word());
      else if (r < 3 + dump_pct + push_pct)
        send(upper ? tss_pkg::OP_PUSH2 : tss_pkg::OP_PUSH1, pick_word());
      else
        send(upper ? tss_pkg::OP_POP2 : tss_pkg::OP_POP1, pick_word());
    end
  endtask

  // empty both stacks, fill one to the whole depth, dump it, overflow the other, pop half of it
  task automatic send_full_run(bit upper);
    for (int k = 0; k < DEPTH; k++) begin
      send(tss_pkg::OP_POP1, pick_word());
      send(tss_pkg::OP_POP2, pick_word());
    end
    for (int k = 0; k < DEPTH; k++)
      send(upper ? tss_pkg::OP_PUSH2 : tss_pkg::OP_PUSH1, pick_word());
    send(upper ? tss_pkg::OP_DUMP2 : tss_pkg::OP_DUMP1, pick_word());
    send(upper ? tss_pkg::OP_PUSH1 : tss_pkg::OP_PUSH2, pick_word());
    for (int k = 0; k < DEPTH / 2; k++)
      send(upper ? tss_pkg::OP_POP2 : tss_pkg::OP_POP1, pick_word());
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (ops_taken != ops_queued || owed_results.size() != 0);
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.opcode     = '0;
    in_bus.push_value = '0;
    out_bus.ready     = 1'b0;
    idle_on           = 1'b0;
    ops_queued        = 0;
    ops_taken         = 0;
    beats_taken       = 0;
    mismatches        = 0;
    quiet_cycles      = 0;
    lower_depth       = 0;
    upper_top         = DEPTH;
    for (int k = 0; k < DEPTH; k++) shadow_words[k] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty stacks, unused opcodes, extremes, full memory, dumps
    send(tss_pkg::OP_POP1, 32'h7fff_ffff);
    send(tss_pkg::OP_POP2, 32'h8000_0000);
    send(tss_pkg::OP_DUMP1, '1);
    send(tss_pkg::OP_DUMP2, '0);
    send(OP_SPARE_A, 32'h1234_5678);
    send(OP_SPARE_B, '1);
    send(tss_pkg::OP_PUSH1, 32'h7fff_ffff);
    send(tss_pkg::OP_PUSH1, 32'h8000_0000);
    send(tss_pkg::OP_PUSH1, '0);
    send(tss_pkg::OP_PUSH2, '1);
    send(tss_pkg::OP_PUSH2, 32'h5555_5555);
    send(tss_pkg::OP_PUSH2, 32'haaaa_aaaa);
    send(tss_pkg::OP_PUSH2, 32'h0000_0001);
    send(tss_pkg::OP_PUSH2, 32'h1234_5678);
    send(tss_pkg::OP_PUSH1, 32'hdead_beef);
    send(tss_pkg::OP_PUSH2, 32'hcafe_f00d);
    send(tss_pkg::OP_DUMP1, '0);
    send(tss_pkg::OP_DUMP2, '0);
    send(tss_pkg::OP_POP2, '0);
    send(tss_pkg::OP_POP1, '0);
    send(tss_pkg::OP_PUSH2, 32'h0f0f_0f0f);
    send(tss_pkg::OP_DUMP2, '0);
    send(tss_pkg::OP_DUMP1, '0);
    wait_drained();

    // random traffic with idling on both sides
    idle_on = 1'b1;
    send_mix(60, 65, 12);
    send_mix(60, 20, 12);
    wait_drained();

    send_full_run(1'b0);
    send_full_run(1'b1);

    // a stretch with no idling
    wait_drained();
    idle_on = 1'b0;
    send_mix(40, 45, 15);
    wait_drained();

    idle_on = 1'b1;
    send_mix(60, 65, 12);
    send_mix(50, 45, 15);
    wait_drained();

    // closing part without idling
    idle_on = 1'b0;
    send_mix(30, 45, 15);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
design/tss_pkg.sv
design/tss_if.sv
design/tss_ram.sv
design/tss_ctrl.sv
design/tss_dp.sv
design/two_stacks_shared_array.sv
design/tss_checker.sv
verif/tb_two_stacks_shared_array.sv
